// File: hdl/tpt_pkg.sv
// Shared types and constants for the touchpad motion and tap tracker.
`default_nettype none
package tpt_pkg;

    localparam int KIND_W    = 2;
    localparam int BUTTON_W  = 3;
    localparam int STEP_BITS = 18;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int LIMIT_W   = 16;

    localparam logic [KIND_W-1:0] KIND_AXIS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;

    localparam logic [BUTTON_W-1:0] BTN_LAST_FINGER = 3'd3;
    localparam logic [BUTTON_W-1:0] BTN_CONTACT     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_SLOP = 3'd5;

    localparam logic [LIMIT_W-1:0] TAP_LIMIT_RESET = 16'd180;
    localparam logic [LIMIT_W-1:0] TAP_SLOP_RESET  = 16'd14;

    typedef struct packed {
        logic have_report;
        logic multi_finger;
        logic touch_down;
    } touch_stat_t;

    typedef struct packed {
        logic x_still;
        logic y_still;
    } motion_stat_t;

endpackage
`default_nettype wire

// File: hdl/touchpad_motion_and_tap_tracker.sv
// Top level of the touchpad motion and tap tracker.
// Takes one word per cycle. A word is captured in the input register and is
// evaluated in a single pass from that register into the result register,
// together with the tracker state update, and a new word can follow every cycle.
// Throughput drops only when m_tready holds the result register; the input
// register then fills and s_tready falls. Every input word yields exactly one
// result word.
`default_nettype none
module touchpad_motion_and_tap_tracker #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // axis, position, button, pressed, time_ms
    input  wire logic [((COORD_BITS+TIME_BITS+5+7)/8)*8-1:0]   s_tdata,
    // kind
    input  wire logic [tpt_pkg::KIND_W-1:0]                    s_tuser,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // step, tap
    output logic [tpt_pkg::OUT_W-1:0]                          m_tdata,
    input  wire logic                                          cfg_wr_en,
    input  wire logic [tpt_pkg::CFG_IDX_W-1:0]                 cfg_index,
    input  wire logic [(COORD_BITS > 16 ? COORD_BITS : 16)-1:0] cfg_data
);
    import tpt_pkg::*;

    logic signed [COORD_BITS-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic [LIMIT_W-1:0]           tap_limit_reg, tap_slop_reg;

    logic                         in_valid_reg, in_valid_next;
    logic [KIND_W-1:0]            kind_reg;
    logic                         axis_reg;
    logic signed [COORD_BITS-1:0] position_reg;
    logic [BUTTON_W-1:0]          button_reg;
    logic                         pressed_reg;
    logic [TIME_BITS-1:0]         time_reg;

    logic                         out_valid_reg, out_valid_next;
    logic signed [STEP_BITS-1:0]  step_reg, step_next;
    logic                         tap_reg, tap_next;

    logic                         advance, in_take;
    touch_stat_t                  touch;
    motion_stat_t                 mstat;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-STEP_BITS-1){1'b0}}, tap_reg, step_reg};

    always_comb begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg     <= '0;
            x_high_reg    <= '0;
            y_low_reg     <= '0;
            y_high_reg    <= '0;
            tap_limit_reg <= TAP_LIMIT_RESET;
            tap_slop_reg  <= TAP_SLOP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_X_LOW:    x_low_reg     <= cfg_data[COORD_BITS-1:0];
                REG_X_HIGH:   x_high_reg    <= cfg_data[COORD_BITS-1:0];
                REG_Y_LOW:    y_low_reg     <= cfg_data[COORD_BITS-1:0];
                REG_Y_HIGH:   y_high_reg    <= cfg_data[COORD_BITS-1:0];
                REG_TAP_TIME: tap_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_TAP_SLOP: tap_slop_reg  <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg     <= s_tuser;
            axis_reg     <= s_tdata[0];
            position_reg <= s_tdata[COORD_BITS:1];
            button_reg   <= s_tdata[COORD_BITS+3:COORD_BITS+1];
            pressed_reg  <= s_tdata[COORD_BITS+4];
            time_reg     <= s_tdata[COORD_BITS+TIME_BITS+4:COORD_BITS+5];
        end
        if (advance) begin
            step_reg <= step_next;
            tap_reg  <= tap_next;
        end
    end

    tpt_motion #(
        .COORD_BITS (COORD_BITS)
    ) u_motion (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .kind     (kind_reg),
        .axis     (axis_reg),
        .position (position_reg),
        .x_low    (x_low_reg),
        .x_high   (x_high_reg),
        .y_low    (y_low_reg),
        .y_high   (y_high_reg),
        .tap_slop (tap_slop_reg),
        .touch    (touch),
        .mstat    (mstat),
        .step     (step_next)
    );

    tpt_tap #(
        .TIME_BITS (TIME_BITS)
    ) u_tap (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .kind           (kind_reg),
        .button         (button_reg),
        .pressed        (pressed_reg),
        .time_ms        (time_reg),
        .tap_time_limit (tap_limit_reg),
        .mstat          (mstat),
        .touch          (touch),
        .tap            (tap_next)
    );

`ifndef SYNTH
    a_tap_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && tap_reg) |-> (step_reg == '0))
        else $error("tap word carries a step");

    a_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("pending word dropped while result stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with free buffer space");
`endif

endmodule
`default_nettype wire

// File: hdl/tpt_motion.sv
// Axis sample handling: position tracking, jump rejection, travel and scaled step.
`default_nettype none
module tpt_motion #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               advance,
    input  wire logic [tpt_pkg::KIND_W-1:0]         kind,
    input  wire logic                               axis,
    input  wire logic signed [COORD_BITS-1:0]       position,
    input  wire logic signed [COORD_BITS-1:0]       x_low,
    input  wire logic signed [COORD_BITS-1:0]       x_high,
    input  wire logic signed [COORD_BITS-1:0]       y_low,
    input  wire logic signed [COORD_BITS-1:0]       y_high,
    input  wire logic [tpt_pkg::LIMIT_W-1:0]        tap_slop,
    input  wire tpt_pkg::touch_stat_t               touch,
    output tpt_pkg::motion_stat_t                   mstat,
    output logic signed [tpt_pkg::STEP_BITS-1:0]    step
);
    import tpt_pkg::*;

    localparam int SW  = (COORD_BITS + 3 > STEP_BITS) ? COORD_BITS + 3 : STEP_BITS;
    localparam int SLW = (COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W;

    localparam logic signed [SW-1:0] STEP_ONE   = SW'(1);
    localparam logic signed [SW-1:0] STEP_MINUS = '1;

    logic signed [COORD_BITS-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [COORD_BITS-1:0]        travel_x_reg, travel_x_next, travel_y_reg, travel_y_next;

    logic signed [COORD_BITS-1:0] prev, lo, hi;
    logic signed [COORD_BITS:0]   d, span;
    logic [COORD_BITS:0]          mag, quarter;
    logic [COORD_BITS-1:0]        travel_cur, travel_upd;
    logic [COORD_BITS+1:0]        travel_sum;
    logic signed [SW-1:0]         d_wide, triple, half_sum, half, step_full;
    logic                         is_axis, take, move, jump, range_ok;

    always_comb begin
        prev     = axis ? last_y_reg : last_x_reg;
        lo       = axis ? y_low : x_low;
        hi       = axis ? y_high : x_high;
        d        = (COORD_BITS+1)'(position) - (COORD_BITS+1)'(prev);
        span     = (COORD_BITS+1)'(hi) - (COORD_BITS+1)'(lo);
        range_ok = hi > lo;
        quarter  = unsigned'(span >>> 2);
        mag      = d[COORD_BITS] ? unsigned'(-d) : unsigned'(d);
        jump     = range_ok && (mag > quarter);

        is_axis  = kind == KIND_AXIS;
        take     = is_axis && !touch.multi_finger;
        move     = take && touch.have_report && !jump;

        travel_cur = axis ? travel_y_reg : travel_x_reg;
        travel_sum = (COORD_BITS+2)'(travel_cur) + (COORD_BITS+2)'(mag);
        travel_upd = (travel_sum >= (COORD_BITS+2)'({COORD_BITS{1'b1}}))
                     ? {COORD_BITS{1'b1}} : travel_sum[COORD_BITS-1:0];

        // d * 3 / 2, rounded toward zero
        d_wide   = SW'(d);
        triple   = d_wide + (d_wide <<< 1);
        half_sum = triple + signed'(SW'(triple[SW-1]));
        half     = half_sum >>> 1;
        if (half == '0 && d != '0) begin
            step_full = d[COORD_BITS] ? STEP_MINUS : STEP_ONE;
        end else begin
            step_full = half;
        end
        step = move ? step_full[STEP_BITS-1:0] : '0;

        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        travel_x_next = travel_x_reg;
        travel_y_next = travel_y_reg;
        if (take) begin
            if (axis) begin
                last_y_next = position;
            end else begin
                last_x_next = position;
            end
        end
        if (move) begin
            if (axis) begin
                travel_y_next = travel_upd;
            end else begin
                travel_x_next = travel_upd;
            end
        end
        if (touch.touch_down) begin
            travel_x_next = '0;
            travel_y_next = '0;
        end

        mstat.x_still = SLW'(travel_x_reg) < SLW'(tap_slop);
        mstat.y_still = SLW'(travel_y_reg) < SLW'(tap_slop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            travel_x_reg <= '0;
            travel_y_reg <= '0;
        end else if (advance) begin
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            travel_x_reg <= travel_x_next;
            travel_y_reg <= travel_y_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tpt_tap.sv
// Finger count, touch timing, report tracking and tap recognition.
`default_nettype none
module tpt_tap #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic [tpt_pkg::KIND_W-1:0]    kind,
    input  wire logic [tpt_pkg::BUTTON_W-1:0]  button,
    input  wire logic                          pressed,
    input  wire logic [TIME_BITS-1:0]          time_ms,
    input  wire logic [tpt_pkg::LIMIT_W-1:0]   tap_time_limit,
    input  wire tpt_pkg::motion_stat_t         mstat,
    output tpt_pkg::touch_stat_t               touch,
    output logic                               tap
);
    import tpt_pkg::*;

    logic                 have_report_reg, have_report_next;
    logic [BUTTON_W-1:0]  finger_count_reg, finger_count_next;
    logic [TIME_BITS-1:0] touch_time_reg, touch_time_next;

    logic [TIME_BITS-1:0] elapsed;
    logic                 is_btn, touch_ev, quick, one;

    always_comb begin
        is_btn   = kind == KIND_BUTTON;
        touch_ev = is_btn && button == BTN_CONTACT;
        elapsed  = time_ms - touch_time_reg;
        quick    = elapsed < TIME_BITS'(tap_time_limit);
        one      = finger_count_reg <= 3'd1;
        tap      = touch_ev && !pressed && quick && mstat.x_still && mstat.y_still && one;

        touch.have_report  = have_report_reg;
        touch.multi_finger = !one;
        touch.touch_down   = advance && touch_ev && pressed;

        have_report_next  = have_report_reg;
        finger_count_next = finger_count_reg;
        touch_time_next   = touch_time_reg;
        if (kind == KIND_SYNC) begin
            have_report_next = 1'b1;
        end
        if (is_btn && button <= BTN_LAST_FINGER && pressed) begin
            finger_count_next = button + 3'd1;
        end
        if (touch_ev) begin
            have_report_next = 1'b0;
            if (pressed) begin
                touch_time_next = time_ms;
            end else begin
                finger_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_report_reg  <= 1'b0;
            finger_count_reg <= '0;
            touch_time_reg   <= '0;
        end else if (advance) begin
            have_report_reg  <= have_report_next;
            finger_count_reg <= finger_count_next;
            touch_time_reg   <= touch_time_next;
        end
    end

`ifndef SYNTH
    a_finger_range: assert property (@(posedge aclk) disable iff (!aresetn)
        finger_count_reg <= 3'd4)
        else $error("finger count out of range");
`endif

endmodule
`default_nettype wire
